// File: rtl/core/image_mirror_rotate_invert_top_defines.svh
// Assertion macros shared by the frame transform checker.
`ifndef IMAGE_MIRROR_ROTATE_INVERT_TOP_DEFINES_SVH
`define IMAGE_MIRROR_ROTATE_INVERT_TOP_DEFINES_SVH

// Check that a condition implies another at the same edge.
`define IMRI_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("frame transform check failed");

// Check that a condition is followed by another a fixed number of cycles later.
`define IMRI_ASSERT_AFTER(label, clk, rst_n, ante, n, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
		else $error("frame transform latency check failed");

`endif

// File: rtl/core/imri_pkg.sv
// Shared types and constants of the frame transform engine.
package imri_pkg;

	localparam int SIZE_W = 9;
	localparam int PIX_W = 32;
	localparam int DEF_MAX_WIDTH = 256;
	localparam int DEF_MAX_HEIGHT = 256;
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	localparam logic [PIX_W-1:0] PIX_ONES = 32'hFFFF_FFFF;
	localparam logic [SIZE_W-1:0] RST_SIZE = 9'd256;

	// Register indexes, taken from paddr[3:2]
	localparam logic [1:0] REG_MODE = 2'd0;
	localparam logic [1:0] REG_WIDTH = 2'd1;
	localparam logic [1:0] REG_HEIGHT = 2'd2;

	typedef enum logic [1:0] {
		MODE_INVERT = 2'd0,
		MODE_HMIRROR = 2'd1,
		MODE_VMIRROR = 2'd2,
		MODE_ROTATE = 2'd3
	} mode_t;

	typedef enum logic {
		ST_FILL = 1'b0,
		ST_DRAIN = 1'b1
	} state_t;

	// Effective configuration, sizes already clamped
	typedef struct packed {
		mode_t mode;
		logic [SIZE_W-1:0] width;
		logic [SIZE_W-1:0] height;
	} cfg_t;

	// Controller to datapath
	typedef struct packed {
		logic wr;
		logic rd;
		logic nr;
		logic restart;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic last_src;
		logic last_rd;
	} sts_t;

endpackage

// File: rtl/core/imri_regs.sv
// APB configuration registers of the frame transform engine.
module imri_regs #(
	parameter int MAX_WIDTH = imri_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = imri_pkg::DEF_MAX_HEIGHT
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [imri_pkg::PADDR_W-1:0] paddr,
	input  logic [imri_pkg::PDATA_W-1:0] pwdata,
	output logic [imri_pkg::PDATA_W-1:0] prdata,
	output logic                         pready,
	output imri_pkg::cfg_t               cfg,
	output logic                         cfg_busy,
	output logic                         restart
);
	import imri_pkg::*;

	logic [1:0]        mode_q;
	logic [SIZE_W-1:0] width_q;
	logic [SIZE_W-1:0] height_q;
	logic [1:0]        index;
	logic              wr_access;

	assign pready = 1'b1;
	assign index = paddr[3:2];
	assign wr_access = psel & penable & pwrite;
	assign cfg_busy = wr_access;
	assign restart = wr_access & ((index == REG_MODE) | (index == REG_WIDTH) |
		(index == REG_HEIGHT));

	// Store register words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_INVERT;
			width_q <= RST_SIZE;
			height_q <= RST_SIZE;
		end else if (wr_access) begin
			case (index)
				REG_MODE: mode_q <= pwdata[1:0];
				REG_WIDTH: width_q <= pwdata[SIZE_W-1:0];
				REG_HEIGHT: height_q <= pwdata[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	// Return register values
	always_comb begin
		case (index)
			REG_MODE: prdata = {{(PDATA_W-2){1'b0}}, mode_q};
			REG_WIDTH: prdata = {{(PDATA_W-SIZE_W){1'b0}}, width_q};
			REG_HEIGHT: prdata = {{(PDATA_W-SIZE_W){1'b0}}, height_q};
			default: prdata = '0;
		endcase
	end

	// Clamp sizes: zero counts as one, too large counts as the maximum
	always_comb begin
		cfg.mode = mode_t'(mode_q);
		if (width_q == '0) begin
			cfg.width = SIZE_W'(1);
		end else if (32'(width_q) > MAX_WIDTH) begin
			cfg.width = SIZE_W'(MAX_WIDTH);
		end else begin
			cfg.width = width_q;
		end
		if (height_q == '0) begin
			cfg.height = SIZE_W'(1);
		end else if (32'(height_q) > MAX_HEIGHT) begin
			cfg.height = SIZE_W'(MAX_HEIGHT);
		end else begin
			cfg.height = height_q;
		end
	end

endmodule

// File: rtl/core/imri_ctrl.sv
// Fill/drain controller of the frame transform engine.
module imri_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic           operation,
	input  logic           cfg_busy,
	input  logic           restart,
	input  imri_pkg::sts_t sts,
	output logic           busy,
	output imri_pkg::cmd_t cmd
);
	import imri_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   accept;

	// Hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FILL;
		end else begin
			state_q <= state_d;
		end
	end

	// Decode the accepted word and pick the next state
	always_comb begin
		busy = cfg_busy;
		accept = start & ~cfg_busy;
		cmd.restart = restart;
		cmd.wr = 1'b0;
		cmd.rd = 1'b0;
		cmd.nr = 1'b0;
		state_d = state_q;
		case (state_q)
			ST_FILL: begin
				cmd.wr = accept & ~operation;
				cmd.nr = accept & operation;
				if (cmd.wr && sts.last_src) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				cmd.rd = accept & operation;
				if (cmd.rd && sts.last_rd) begin
					state_d = ST_FILL;
				end
			end
			default: state_d = ST_FILL;
		endcase
		if (restart) begin
			state_d = ST_FILL;
		end
	end

endmodule

// File: rtl/core/imri_dp.sv
// Position counters, address pipeline and frame store of the transform engine.
module imri_dp #(
	parameter int MAX_WIDTH = imri_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = imri_pkg::DEF_MAX_HEIGHT
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  imri_pkg::cfg_t             cfg,
	input  imri_pkg::cmd_t             cmd,
	input  logic [imri_pkg::PIX_W-1:0] pixel_in,
	output imri_pkg::sts_t             sts,
	output logic                       done,
	output logic [imri_pkg::PIX_W-1:0] pixel_out,
	output logic                       last_pixel,
	output logic                       not_ready
);
	import imri_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int PW = (CW > RW) ? CW : RW;
	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW = $clog2(DEPTH);
	localparam int TW = $clog2(DEPTH + 1);
	localparam int XW = SIZE_W + PW;

	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [AW-1:0] ridx_q;
	logic [TW-1:0] total_q;

	logic [XW-1:0] w_x, h_x, col_x, row_x;
	logic          col_end, row_end;

	logic [PW-1:0]     mul_a, addend;
	logic [SIZE_W-1:0] mul_b;
	logic [PIX_W-1:0]  wpix;

	logic              wr_s1, rd_s1, nr_s1, last_s1;
	logic [PW-1:0]     a_s1, add_s1;
	logic [SIZE_W-1:0] b_s1;
	logic [PIX_W-1:0]  pix_s1;
	logic [AW-1:0]     raddr_s1;

	logic              wr_s2, rd_s2, nr_s2, last_s2;
	logic [AW-1:0]     prod_s2, raddr_s2, waddr;
	logic [PW-1:0]     add_s2;
	logic [PIX_W-1:0]  pix_s2;

	logic              out_s3, nr_s3, last_s3;
	logic [PIX_W-1:0]  rdata_s3;

	logic [PIX_W-1:0] mem [DEPTH];

	assign w_x = XW'(cfg.width);
	assign h_x = XW'(cfg.height);
	assign col_x = XW'(col_q);
	assign row_x = XW'(row_q);
	assign col_end = (col_x + XW'(1)) >= w_x;
	assign row_end = (row_x + XW'(1)) >= h_x;
	assign sts.last_src = col_end & row_end;
	assign sts.last_rd = (TW'(ridx_q) + TW'(1)) >= total_q;

	// Track frame size for the end of the read sweep
	always_ff @(posedge clk) begin
		total_q <= TW'({{SIZE_W{1'b0}}, cfg.width} * {{SIZE_W{1'b0}}, cfg.height});
	end

	// Advance source position and read index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			ridx_q <= '0;
		end else if (cmd.restart) begin
			col_q <= '0;
			row_q <= '0;
			ridx_q <= '0;
		end else begin
			if (cmd.wr) begin
				if (col_end) begin
					col_q <= '0;
					row_q <= row_end ? '0 : row_q + RW'(1);
				end else begin
					col_q <= col_q + CW'(1);
				end
			end
			if (cmd.rd) begin
				ridx_q <= sts.last_rd ? '0 : ridx_q + AW'(1);
			end
		end
	end

	// Select multiplier operands and offset for the destination address, and invert the pixel in invert mode
	always_comb begin
		wpix = pixel_in;
		case (cfg.mode)
			MODE_INVERT: begin
				mul_a = PW'(row_x);
				mul_b = cfg.width;
				addend = PW'(col_x);
				wpix = pixel_in ^ PIX_ONES;
			end
			MODE_HMIRROR: begin
				mul_a = PW'(row_x);
				mul_b = cfg.width;
				addend = PW'(w_x - XW'(1) - col_x);
			end
			MODE_VMIRROR: begin
				mul_a = PW'(h_x - XW'(1) - row_x);
				mul_b = cfg.width;
				addend = PW'(col_x);
			end
			MODE_ROTATE: begin
				mul_a = PW'(col_x);
				mul_b = cfg.height;
				addend = PW'(h_x - XW'(1) - row_x);
			end
			default: begin
				mul_a = PW'(row_x);
				mul_b = cfg.width;
				addend = PW'(col_x);
			end
		endcase
	end

	// Pipeline valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_s1 <= 1'b0;
			rd_s1 <= 1'b0;
			nr_s1 <= 1'b0;
			wr_s2 <= 1'b0;
			rd_s2 <= 1'b0;
			nr_s2 <= 1'b0;
			out_s3 <= 1'b0;
		end else begin
			wr_s1 <= cmd.wr;
			rd_s1 <= cmd.rd;
			nr_s1 <= cmd.nr;
			wr_s2 <= wr_s1;
			rd_s2 <= rd_s1;
			nr_s2 <= nr_s1;
			out_s3 <= rd_s2 | nr_s2;
		end
	end

	// Stage 1 captures operands, stage 2 holds the product
	always_ff @(posedge clk) begin
		a_s1 <= mul_a;
		b_s1 <= mul_b;
		add_s1 <= addend;
		pix_s1 <= wpix;
		raddr_s1 <= ridx_q;
		last_s1 <= cmd.rd & sts.last_rd;
		prod_s2 <= AW'(a_s1) * AW'(b_s1);
		add_s2 <= add_s1;
		pix_s2 <= pix_s1;
		raddr_s2 <= raddr_s1;
		last_s2 <= last_s1;
		nr_s3 <= nr_s2;
		last_s3 <= last_s2;
	end

	assign waddr = prod_s2 + AW'(add_s2);

	// Frame store: write the placed pixel, read the next output word
	always_ff @(posedge clk) begin
		if (wr_s2) begin
			mem[waddr] <= pix_s2;
		end
		if (rd_s2) begin
			rdata_s3 <= mem[raddr_s2];
		end
	end

	assign done = out_s3;
	assign pixel_out = nr_s3 ? '0 : rdata_s3;
	assign last_pixel = last_s3 & ~nr_s3;
	assign not_ready = nr_s3;

endmodule

// File: rtl/core/image_mirror_rotate_invert_top.sv
// Top level of the frame transform engine: registers, controller and datapath.
//
//   channel   kind     handshake                      word
//   item in   command  start & !busy                  operation, pixel_in
//   result    strobe   done, one cycle, no stall      pixel_out, last_pixel, not_ready
//   config    APB      psel & penable & pwrite        transform_mode, image_width, image_height
//
// One item is taken every cycle while busy is low; a read returns its result
// through the operand, multiply and frame store read stages.
// busy is high only during an APB write access cycle.
// Reset clears the counters, the fill/drain state and the pipeline valid bits;
// the frame store is not cleared and holds garbage until a frame is written.
// The result side cannot stall, so nothing ever backs up into start.
module image_mirror_rotate_invert_top #(
	parameter int MAX_WIDTH = imri_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = imri_pkg::DEF_MAX_HEIGHT
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic                         operation,
	input  logic [imri_pkg::PIX_W-1:0]   pixel_in,
	output logic                         done,
	output logic [imri_pkg::PIX_W-1:0]   pixel_out,
	output logic                         last_pixel,
	output logic                         not_ready,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [imri_pkg::PADDR_W-1:0] paddr,
	input  logic [imri_pkg::PDATA_W-1:0] pwdata,
	output logic [imri_pkg::PDATA_W-1:0] prdata,
	output logic                         pready
);
	import imri_pkg::*;

	cfg_t cfg;
	cmd_t cmd;
	sts_t sts;
	logic cfg_busy;
	logic restart;

	imri_regs #(
		.MAX_WIDTH(MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_regs (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.cfg(cfg),
		.cfg_busy(cfg_busy),
		.restart(restart)
	);

	imri_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.operation(operation),
		.cfg_busy(cfg_busy),
		.restart(restart),
		.sts(sts),
		.busy(busy),
		.cmd(cmd)
	);

	imri_dp #(
		.MAX_WIDTH(MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.cmd(cmd),
		.pixel_in(pixel_in),
		.sts(sts),
		.done(done),
		.pixel_out(pixel_out),
		.last_pixel(last_pixel),
		.not_ready(not_ready)
	);

endmodule

// File: rtl/core/imri_checker.sv
// Port-level checks of the frame transform engine and their binding.
`include "image_mirror_rotate_invert_top_defines.svh"

module imri_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       start,
	input logic                       busy,
	input logic                       operation,
	input logic                       done,
	input logic [imri_pkg::PIX_W-1:0] pixel_out,
	input logic                       last_pixel,
	input logic                       not_ready
);

	// Every taken read yields a result
	`IMRI_ASSERT_AFTER(a_read_gives_result, clk, arst_n, arst_n && start && !busy && operation, 3, done)

	// No result without an earlier taken read
	`IMRI_ASSERT_IMPLY(a_result_from_read, clk, arst_n, done, $past(arst_n && start && !busy && operation, 3))

	// An early read carries a zero pixel
	`IMRI_ASSERT_IMPLY(a_not_ready_zero, clk, arst_n, done && not_ready, pixel_out == '0)

	// An early read never closes a frame
	`IMRI_ASSERT_IMPLY(a_not_ready_not_last, clk, arst_n, done && not_ready, !last_pixel)

endmodule

bind image_mirror_rotate_invert_top imri_checker u_imri_checker (.*);

// File: test/image_mirror_rotate_invert_top_tb.sv
// Self-checking testbench for the frame transform engine: directed table, then random frames.
module image_mirror_rotate_invert_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import imri_pkg::*;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_READ = 1'b1;
	localparam int RESULT_LATENCY = 3;
	localparam int ITEM_TARGET = 2000;
	localparam int QUIET_TAIL = 300;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int STORE_WORDS = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;

	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic             last;
		logic             nr;
	} frame_result_t;

	typedef struct packed {
		logic             is_reg;
		logic [1:0]       reg_idx;
		logic             op;
		logic [31:0]      value;
		logic             typed;
		frame_result_t    want;
	} script_row_t;

	localparam frame_result_t NO_RESULT = '0;
	localparam frame_result_t NOT_READY = '{32'h0, 1'b0, 1'b1};

	// Directed stimulus; typed results only where they are obvious
	localparam int SCRIPT_ROWS = 37;
	localparam script_row_t SCRIPT [SCRIPT_ROWS] = '{
		'{1'b0, REG_MODE, OP_READ, 32'h0, 1'b1, NOT_READY},
		'{1'b1, REG_WIDTH, OP_WRITE, 32'd2, 1'b0, NO_RESULT},
		'{1'b1, REG_HEIGHT, OP_WRITE, 32'd2, 1'b0, NO_RESULT},
		'{1'b1, REG_MODE, OP_WRITE, 32'(MODE_INVERT), 1'b0, NO_RESULT},
		'{1'b0, REG_MODE, OP_WRITE, 32'h0000_0000, 1'b0, NO_RESULT},
		'{1'b0, REG_MODE, OP_WRITE, 32'hFFFF_FFFF, 1'b0, NO_RESULT},
		'{1'b0, REG_MODE, OP_WRITE, 32'hA5A5_A5A5, 1'b0, NO_RESULT},
		'{1'b0, REG_MODE, OP_WRITE, 32'h1234_5678, 1'b0, NO_RESULT},
		'{1'b0, REG_MODE, OP_READ, 32'h0, 1'b1, '{32'hFFFF_FFFF, 1'b0, 1'b0}},
		'{1'b0, REG_MODE, OP_READ, 32'h0, 1'b1, '{32'h0000_0000, 1'b0, 1'b0}},
		'{1'b0, REG_MODE, OP_READ, 32'h0, 1'b1, '{32'h5A5A_5A5A, 1'b0, 1'b0}},
		'{1'b0, REG_MODE, OP_READ, 32'h0, 1'b1, '{32'hEDCB_A987, 1'b1, 1'b0}},
		'{1'b0, REG_MODE, OP_READ, 32'h0, 1'b1, NOT_READY},
		'{1'b1, REG_MODE, OP_WRITE, 32'(MODE_ROTATE), 1'b0, NO_RESULT},
		'{1'b0, REG_MODE, OP_WRITE, 32'h1111_1111, 1'b0, NO_RESULT},
		'{1'b0, REG_MODE, OP_WRITE, 32'h2222_2222, 1'b0, NO_RESULT},
		'{1'b0, REG_MODE, OP_WRITE, 32'h3333_3333, 1'b0, NO_RESULT},
		'{1'b0, REG_MODE, OP_WRITE, 32'h4444_4444, 1'b0, NO_RESULT},
		'{1'b0, REG_MODE, OP_WRITE, 32'h0BAD_F00D, 1'b0, NO_RESULT},
		'{1'b0, REG_MODE, OP_READ, 32'h0, 1'b0, NO_RESULT},
		'{1'b0, REG_MODE, OP_READ, 32'h0, 1'b0, NO_RESULT},
		'{1'b0, REG_MODE, OP_READ, 32'h0, 1'b0, NO_RESULT},
		'{1'b0, REG_MODE, OP_READ, 32'h0, 1'b0, NO_RESULT},
		'{1'b1, REG_MODE, OP_WRITE, 32'(MODE_HMIRROR), 1'b0, NO_RESULT},
		'{1'b1, REG_HEIGHT, OP_WRITE, 32'd1, 1'b0, NO_RESULT},
		'{1'b0, REG_MODE, OP_WRITE, 32'hCAFE_BABE, 1'b0, NO_RESULT},
		'{1'b0, REG_MODE, OP_WRITE, 32'h0F0F_0F0F, 1'b0, NO_RESULT},
		'{1'b0, REG_MODE, OP_READ, 32'h0, 1'b0, NO_RESULT},
		'{1'b0, REG_MODE, OP_READ, 32'h0, 1'b0, NO_RESULT},
		'{1'b1, REG_MODE, OP_WRITE, 32'(MODE_VMIRROR), 1'b0, NO_RESULT},
		'{1'b1, REG_WIDTH, OP_WRITE, 32'd0, 1'b0, NO_RESULT},
		'{1'b1, REG_HEIGHT, OP_WRITE, 32'd2, 1'b0, NO_RESULT},
		'{1'b0, REG_MODE, OP_WRITE, 32'hDEAD_BEEF, 1'b0, NO_RESULT},
		'{1'b0, REG_MODE, OP_READ, 32'h0, 1'b1, NOT_READY},
		'{1'b0, REG_MODE, OP_WRITE, 32'h8000_0001, 1'b0, NO_RESULT},
		'{1'b0, REG_MODE, OP_READ, 32'h0, 1'b0, NO_RESULT},
		'{1'b0, REG_MODE, OP_READ, 32'h0, 1'b0, NO_RESULT}
	};

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic                busy;
	logic                operation = OP_WRITE;
	logic [PIX_W-1:0]    pixel_in = '0;
	logic                done;
	logic [PIX_W-1:0]    pixel_out;
	logic                last_pixel;
	logic                not_ready;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [PADDR_W-1:0]  paddr = '0;
	logic [PDATA_W-1:0]  pwdata = '0;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;

	// Predictor state
	logic [PIX_W-1:0]    frame_mem [STORE_WORDS];
	mode_t               cur_mode = MODE_INVERT;
	logic [SIZE_W-1:0]   cur_w = RST_SIZE;
	logic [SIZE_W-1:0]   cur_h = RST_SIZE;
	int unsigned         src_row = 0;
	int unsigned         src_col = 0;
	int unsigned         rd_ptr = 0;
	bit                  frame_full = 1'b0;

	frame_result_t       pending_reads [$];
	int unsigned         mismatches = 0;
	int unsigned         items_sent = 0;
	int unsigned         quiet_cycles = 0;

	image_mirror_rotate_invert_top DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.operation  (operation),
		.pixel_in   (pixel_in),
		.done       (done),
		.pixel_out  (pixel_out),
		.last_pixel (last_pixel),
		.not_ready  (not_ready),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	always #5 clk = ~clk;

	// Size register as the block sees it: zero means one, clip at the maximum
	function automatic int unsigned eff_size(input logic [SIZE_W-1:0] v, input int unsigned lim);
		if (v == 0)
			return 1;
		if (v > lim)
			return lim;
		return v;
	endfunction

	function automatic int unsigned frame_total();
		return eff_size(cur_w, DEF_MAX_WIDTH) * eff_size(cur_h, DEF_MAX_HEIGHT);
	endfunction

	// Register write: update the setting and restart the frame
	function automatic void apply_reg(input logic [1:0] idx, input logic [PDATA_W-1:0] data);
		case (idx)
			REG_MODE: cur_mode = mode_t'(data[1:0]);
			REG_WIDTH: cur_w = data[SIZE_W-1:0];
			REG_HEIGHT: cur_h = data[SIZE_W-1:0];
			default: return;
		endcase
		src_row = 0;
		src_col = 0;
		rd_ptr = 0;
		frame_full = 1'b0;
	endfunction

	// Advance the frame state by one word; return 1 when a result is due
	function automatic bit transform_item(input logic op, input logic [PIX_W-1:0] pix,
			output frame_result_t res);
		int unsigned w, h, r, c, addr;
		logic [PIX_W-1:0] word;
		w = eff_size(cur_w, DEF_MAX_WIDTH);
		h = eff_size(cur_h, DEF_MAX_HEIGHT);
		res = NO_RESULT;
		if (op == OP_WRITE) begin
			if (frame_full)
				return 1'b0;
			word = pix;
			r = (src_row >= h) ? h - 1 : src_row;
			c = (src_col >= w) ? w - 1 : src_col;
			case (cur_mode)
				MODE_INVERT: begin
					addr = r * w + c;
					word = word ^ PIX_ONES;
				end
				MODE_HMIRROR: addr = r * w + (w - 1 - c);
				MODE_VMIRROR: addr = (h - 1 - r) * w + c;
				default: addr = c * h + (h - 1 - r);
			endcase
			frame_mem[addr] = word;
			if (src_col + 1 >= w) begin
				src_col = 0;
				if (src_row + 1 >= h) begin
					src_row = 0;
					frame_full = 1'b1;
					rd_ptr = 0;
				end else begin
					src_row++;
				end
			end else begin
				src_col++;
			end
			return 1'b0;
		end
		if (!frame_full) begin
			res = NOT_READY;
			return 1'b1;
		end
		res.pixel = frame_mem[rd_ptr];
		res.nr = 1'b0;
		if (rd_ptr + 1 >= w * h) begin
			res.last = 1'b1;
			rd_ptr = 0;
			frame_full = 1'b0;
		end else begin
			res.last = 1'b0;
			rd_ptr++;
		end
		return 1'b1;
	endfunction

	// Offer one word and hold it until taken; called at a falling edge
	task automatic send_item(input logic op, input logic [PIX_W-1:0] pix, input logic typed,
			input frame_result_t want);
		frame_result_t res;
		bit has_res;
		bit ignored;
		start <= 1'b1;
		operation <= op;
		pixel_in <= pix;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		ignored = (op == OP_WRITE) && frame_full;
		has_res = transform_item(op, pix, res);
		if (has_res)
			pending_reads.push_back(typed ? want : res);
		if (!ignored)
			items_sent++;
		@(negedge clk);
	endtask

	// Drop start for a random burst of cycles
	task automatic pace(input bit idle_on);
		if (idle_on && items_sent < ITEM_TARGET - QUIET_TAIL && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 5))
				@(negedge clk);
		end
	endtask

	// Hold off until every read result has come back
	task automatic wait_results();
		start <= 1'b0;
		do
			@(negedge clk);
		while (pending_reads.size() != 0);
	endtask

	// Drain and let in-flight writes land before touching a register
	task automatic settle();
		wait_results();
		repeat (RESULT_LATENCY + 2)
			@(negedge clk);
	endtask

	// APB write: setup cycle, then access cycle until pready
	task automatic write_reg(input logic [1:0] idx, input logic [PDATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		apply_reg(idx, data);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	// Check each result strobe against the oldest pending read
	always @(posedge clk) begin
		frame_result_t exp_res;
		if (arst_n && done) begin
			if (pending_reads.size() == 0) begin
				$error("unexpected result: pixel_out %h last_pixel %b not_ready %b",
					pixel_out, last_pixel, not_ready);
				mismatches++;
			end else begin
				exp_res = pending_reads.pop_front();
				if (pixel_out !== exp_res.pixel) begin
					$error("pixel_out mismatch: expected %h, got %h", exp_res.pixel, pixel_out);
					mismatches++;
				end
				if (last_pixel !== exp_res.last) begin
					$error("last_pixel mismatch: expected %b, got %b", exp_res.last, last_pixel);
					mismatches++;
				end
				if (not_ready !== exp_res.nr) begin
					$error("not_ready mismatch: expected %b, got %b", exp_res.nr, not_ready);
					mismatches++;
				end
			end
		end
	end

	// Watchdog: end the run when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || (psel && penable && pwrite)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	// Main sequence
	initial begin
		int unsigned phase;
		int unsigned total;
		int unsigned n;
		logic [SIZE_W-1:0] w_raw;
		logic [SIZE_W-1:0] h_raw;
		bit idle_on;

		repeat (10)
			@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed table
		for (int i = 0; i < SCRIPT_ROWS; i++) begin
			if (SCRIPT[i].is_reg) begin
				settle();
				write_reg(SCRIPT[i].reg_idx, SCRIPT[i].value);
			end else begin
				send_item(SCRIPT[i].op, SCRIPT[i].value, SCRIPT[i].typed, SCRIPT[i].want);
			end
		end

		// Random frames: extreme sizes first, then mostly small ones
		items_sent = 0;
		phase = 0;
		while (items_sent < ITEM_TARGET) begin
			settle();
			case (phase)
				0: begin w_raw = 9'd511; h_raw = 9'd0; end
				1: begin w_raw = 9'd0; h_raw = 9'd511; end
				default: begin
					w_raw = ($urandom_range(0, 9) == 0) ? 9'd0 : 9'($urandom_range(1, 12));
					h_raw = ($urandom_range(0, 9) == 0) ? 9'd0 : 9'($urandom_range(1, 12));
				end
			endcase
			write_reg(REG_MODE, ($urandom & ~32'h3) | 32'($urandom_range(0, 3)));
			write_reg(REG_WIDTH, ($urandom & ~32'h1FF) | 32'(w_raw));
			write_reg(REG_HEIGHT, ($urandom & ~32'h1FF) | 32'(h_raw));
			idle_on = $urandom_range(0, 2) != 0;
			total = frame_total();
			if (phase > 1 && $urandom_range(0, 5) == 0) begin
				// Noise: random mix of reads and writes, often cut short by the next setting
				n = $urandom_range(1, 2 * total);
				repeat (n) begin
					pace(idle_on);
					send_item(1'($urandom_range(0, 1)), $urandom, 1'b0, NO_RESULT);
				end
			end else begin
				repeat ((phase < 2) ? 1 : $urandom_range(1, 2)) begin
					// Fill, with an occasional early read
					for (int i = 0; i < total; i++) begin
						if ($urandom_range(0, 11) == 0) begin
							pace(idle_on);
							send_item(OP_READ, $urandom, 1'b0, NO_RESULT);
						end
						pace(idle_on);
						send_item(OP_WRITE, $urandom, 1'b0, NO_RESULT);
					end
					// Drain, with an occasional dropped write or full hold-off
					for (int i = 0; i < total; i++) begin
						if ($urandom_range(0, 14) == 0) begin
							pace(idle_on);
							send_item(OP_WRITE, $urandom, 1'b0, NO_RESULT);
						end
						if ($urandom_range(0, 29) == 0)
							wait_results();
						pace(idle_on);
						send_item(OP_READ, $urandom, 1'b0, NO_RESULT);
					end
					if ($urandom_range(0, 3) == 0) begin
						pace(idle_on);
						send_item(OP_READ, $urandom, 1'b0, NO_RESULT);
					end
				end
			end
			phase++;
		end

		// Let the last results arrive
		wait_results();
		repeat (RESULT_LATENCY + 5)
			@(negedge clk);
		if (mismatches == 0 && pending_reads.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/imri_pkg.sv
rtl/core/imri_regs.sv
rtl/core/imri_ctrl.sv
rtl/core/imri_dp.sv
rtl/core/image_mirror_rotate_invert_top.sv
rtl/core/imri_checker.sv
test/image_mirror_rotate_invert_top_tb.sv
